// ----- rtl/core/kss_pkg.sv -----
`timescale 1ns / 1ps

package kss_pkg;

  localparam int unsigned MaxWindow = 32;
  localparam int unsigned NumCells  = MaxWindow + 1;
  localparam int unsigned DataW     = 32;
  localparam int unsigned CntW      = $clog2(MaxWindow + 2);
  localparam int unsigned WinW      = 6;
  localparam int unsigned PaddrW    = 3;

  localparam logic RegWindow = 1'b0;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_INSERT     = 2'd1,
    CELL_INSERT_POP = 2'd2,
    CELL_POP        = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     occupied;
    logic     ins_left;
    logic     ins_right;
  } cell_ctl_t;

endpackage

// ----- rtl/core/kss_cell.sv -----
`timescale 1ns / 1ps

module kss_cell import kss_pkg::*; (
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic signed [DataW-1:0] new_val_i,
  input  logic signed [DataW-1:0] left_val_i,
  input  logic signed [DataW-1:0] right_val_i,
  output logic signed [DataW-1:0] val_o,
  output logic                    ins_o
);

  logic signed [DataW-1:0] val_q, val_d;

  // new value belongs at or before this cell
  assign ins_o = !ctl_i.occupied || (new_val_i < val_q);

  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (ins_o) begin
          val_d = ctl_i.ins_left ? left_val_i : new_val_i;
        end
      end
      CELL_INSERT_POP: begin
        if (ctl_i.ins_right) begin
          val_d = ins_o ? val_q : new_val_i;
        end else begin
          val_d = right_val_i;
        end
      end
      CELL_POP: begin
        val_d = right_val_i;
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ----- rtl/core/k_sorted_stream_sorter_top.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        sink       in_valid_i / in_stall_o   value_i, last_i
// out       source     out_valid_o / out_stall_i sorted_value_o, last_of_run_o, end_of_stream_o
// cfg       apb slave  psel, penable, pready     paddr, pwdata, prdata (window_size at 0x0)
//
// one beat per cycle for items without last while in_stall_o is low; the insertion row updates all cells at once
// an item with last starts a drain of all pending values, input stalled meanwhile
// drain emits one value per cycle from the head cell while the output register is free
// reset clears the fill count, drain flag, output valid and sets window_size to 1
// input stalls during a drain and when the output register holds a beat that is itself stalled

module k_sorted_stream_sorter_top import kss_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    last_i,

  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] sorted_value_o,
  output logic                    last_of_run_o,
  output logic                    end_of_stream_o,

  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PaddrW-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [WinW-1:0] window_q;
  logic [CntW-1:0] count_q, count_d;
  logic            flush_q, flush_d;
  logic            out_valid_q;
  logic [WinW-1:0] win_eff;
  logic [CntW-1:0] count_inc;
  logic            out_free, in_fire, drain_fire, pop_now, out_load;
  logic            cfg_wr;
  cell_op_e        op;

  logic signed [DataW-1:0] out_val_q, out_val_d;
  logic                    out_run_q, out_run_d, out_eos_q, out_eos_d;

  logic signed [DataW-1:0] cell_val [NumCells];
  logic                    cell_ins [NumCells];

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegWindow);
  assign prdata = (paddr[2] == RegWindow) ? {{(32-WinW){1'b0}}, window_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WinW'(1);
    end else if (cfg_wr) begin
      window_q <= pwdata[WinW-1:0];
    end
  end

  always_comb begin
    win_eff = window_q;
    if (window_q == '0) begin
      win_eff = WinW'(1);
    end else if (window_q > WinW'(MaxWindow)) begin
      win_eff = WinW'(MaxWindow);
    end
  end

  // handshakes
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = flush_q || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign drain_fire = flush_q && out_free;
  assign count_inc  = count_q + CntW'(1);
  assign pop_now    = !last_i && (CntW'(win_eff) < count_inc);

  always_comb begin
    op        = CELL_HOLD;
    count_d   = count_q;
    flush_d   = flush_q;
    out_load  = 1'b0;
    out_val_d = cell_val[0];
    out_run_d = 1'b1;
    out_eos_d = 1'b0;
    if (drain_fire) begin
      op        = CELL_POP;
      out_load  = 1'b1;
      out_eos_d = (count_q == CntW'(1));
      out_run_d = out_eos_d;
      count_d   = count_q - CntW'(1);
      flush_d   = !out_eos_d;
    end else if (in_fire) begin
      if (last_i) begin
        op      = CELL_INSERT;
        count_d = count_inc;
        flush_d = 1'b1;
      end else if (pop_now) begin
        op        = CELL_INSERT_POP;
        out_load  = 1'b1;
        out_val_d = cell_ins[0] ? value_i : cell_val[0];
      end else begin
        op      = CELL_INSERT;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      flush_q     <= flush_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q <= out_val_d;
      out_run_q <= out_run_d;
      out_eos_q <= out_eos_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sorted_value_o  = out_val_q;
  assign last_of_run_o   = out_run_q;
  assign end_of_stream_o = out_eos_q;

  // insertion row, one spare cell for the value that comes with last on a full window
  for (genvar gi = 0; gi < NumCells; gi++) begin : g_cell
    cell_ctl_t               ctl;
    logic signed [DataW-1:0] left_val, right_val;

    always_comb begin
      ctl.op       = op;
      ctl.occupied = (count_q > CntW'(gi));
      if (gi == 0) begin
        ctl.ins_left = 1'b0;
        left_val     = '0;
      end else begin
        ctl.ins_left = cell_ins[(gi == 0) ? 0 : gi-1];
        left_val     = cell_val[(gi == 0) ? 0 : gi-1];
      end
      if (gi == NumCells-1) begin
        ctl.ins_right = 1'b1;
        right_val     = '0;
      end else begin
        ctl.ins_right = cell_ins[(gi == NumCells-1) ? gi : gi+1];
        right_val     = cell_val[(gi == NumCells-1) ? gi : gi+1];
      end
    end

    kss_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .new_val_i   (value_i),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .val_o       (cell_val[gi]),
      .ins_o       (cell_ins[gi])
    );
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(NumCells))
    else $error("pending count above capacity");

  a_no_input_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> in_stall_o)
    else $error("input taken during drain");

  a_eos_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_stream_o) |-> last_of_run_o)
    else $error("end of stream without end of run");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_fire && count_q == CntW'(1)) |=> (count_q == '0 && !flush_q))
    else $error("drain did not empty the row");

  a_pop_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !last_i && pop_now) |=> $stable(count_q))
    else $error("count changed on insert with pop");
`endif

endmodule

// ----- verif/kss_stream_checker.sv -----
`timescale 1ns / 1ps

module kss_stream_checker import kss_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    last_i,

  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [DataW-1:0] sorted_value_i,
  input  logic                    last_of_run_i,
  input  logic                    end_of_stream_i,

  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic [PaddrW-1:0]       paddr_i,
  input  logic [31:0]             pwdata_i,
  input  logic [31:0]             prdata_i,
  input  logic                    pready_i,

  output int unsigned             fail_count_o,
  output int unsigned             awaited_o,
  output int unsigned             beats_checked_o
);

  localparam logic [PaddrW-1:0] WindowAddr = {RegWindow, 2'b00};

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    run_end;
    logic                    stream_end;
  } sorted_beat_t;

  sorted_beat_t            awaited_beats[$];
  logic signed [DataW-1:0] held_values[$];
  logic [WinW-1:0]         window_reg;

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned  pos;
    int unsigned  limit;
    int unsigned  n;
    sorted_beat_t want;
    sorted_beat_t fresh;
    if (!rst_ni) begin
      awaited_beats.delete();
      held_values.delete();
      window_reg      = WinW'(1);
      fail_count_o    = 0;
      beats_checked_o = 0;
      awaited_o       = 0;
    end else begin
      // output side first: a beat leaving now was predicted at an earlier edge
      if (out_valid_i && !out_stall_i) begin
        beats_checked_o++;
        if (awaited_beats.size() == 0) begin
          $error("unexpected sorted beat: sorted_value %0d", sorted_value_i);
          fail_count_o++;
        end else begin
          want = awaited_beats.pop_front();
          if (sorted_value_i !== want.value) begin
            $error("sorted_value: expected %0d, got %0d", want.value, sorted_value_i);
            fail_count_o++;
          end
          if (last_of_run_i !== want.run_end) begin
            $error("last_of_run: expected %0b, got %0b", want.run_end, last_of_run_i);
            fail_count_o++;
          end
          if (end_of_stream_i !== want.stream_end) begin
            $error("end_of_stream: expected %0b, got %0b", want.stream_end, end_of_stream_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        pos = held_values.size();
        while (pos > 0 && held_values[pos-1] > value_i) pos--;
        held_values.insert(pos, value_i);
        if (last_i) begin
          n = held_values.size();
          for (int j = 0; j < n; j++) begin
            fresh.value      = held_values[j];
            fresh.run_end    = (j == n - 1);
            fresh.stream_end = (j == n - 1);
            awaited_beats.push_back(fresh);
          end
          held_values.delete();
        end else begin
          limit = (window_reg == '0) ? 1 :
                  (window_reg > MaxWindow) ? MaxWindow : window_reg;
          if (held_values.size() > limit) begin
            fresh.value      = held_values.pop_front();
            fresh.run_end    = 1'b1;
            fresh.stream_end = 1'b0;
            awaited_beats.push_back(fresh);
          end
        end
      end

      if (psel_i && penable_i && pready_i && paddr_i == WindowAddr) begin
        if (pwrite_i) begin
          window_reg = pwdata_i[WinW-1:0];
        end else if (prdata_i !== 32'(window_reg)) begin
          $error("window_size readback: expected %0d, got %0d", window_reg, prdata_i);
          fail_count_o++;
        end
      end

      awaited_o = awaited_beats.size();
    end
  end

endmodule

// ----- verif/k_sorted_stream_sorter_top_tb.sv -----
`timescale 1ns / 1ps

module k_sorted_stream_sorter_top_tb;
  import kss_pkg::*;

  localparam logic [PaddrW-1:0] WindowAddr = {RegWindow, 2'b00};
  localparam logic [PaddrW-1:0] UnusedAddr = 3'd4;
  localparam int RandomItems = 420;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [DataW-1:0] in_value = '0;
  logic                    in_last = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [DataW-1:0] sorted_value;
  logic                    last_of_run;
  logic                    end_of_stream;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PaddrW-1:0]       paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  int unsigned fail_count;
  int unsigned awaited;
  int unsigned beats_checked;

  int          items_sent;
  int          window_writes;
  int          burst_left;
  int          cur_window;
  stall_mode_e stall_mode;
  int          stall_left;

  k_sorted_stream_sorter_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .value_i         (in_value),
    .last_i          (in_last),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .sorted_value_o  (sorted_value),
    .last_of_run_o   (last_of_run),
    .end_of_stream_o (end_of_stream),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  kss_stream_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .value_i         (in_value),
    .last_i          (in_last),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .sorted_value_i  (sorted_value),
    .last_of_run_i   (last_of_run),
    .end_of_stream_i (end_of_stream),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .fail_count_o    (fail_count),
    .awaited_o       (awaited),
    .beats_checked_o (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // receiver stall pattern, switching among four modes at random
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
      default:     out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  task automatic send_beat(input logic signed [DataW-1:0] v, input logic l);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= l;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic apb_access(input logic [PaddrW-1:0] a, input logic [31:0] d, input logic wr);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // drain outstanding beats, let the block go quiet, write, then read back
  task automatic reconfigure(input logic [PaddrW-1:0] a, input logic [31:0] d);
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (MaxWindow + 4) @(negedge clk);
    apb_access(a, d, 1'b1);
    apb_access(WindowAddr, '0, 1'b0);
    if (a == WindowAddr) begin
      cur_window = (d[WinW-1:0] == 0) ? 1 :
                   (d[WinW-1:0] > MaxWindow) ? MaxWindow : int'(d[WinW-1:0]);
    end
    window_writes++;
  endtask

  // nearly sorted run: ascending base (random values when scrambled), shuffled inside blocks of k
  task automatic send_run(input int k, input int len, input bit scrambled, input bit with_last);
    logic signed [DataW-1:0] vals[$];
    logic signed [DataW-1:0] tmp;
    longint                  cur;
    longint                  step_max;
    int                      pick;
    int                      stop;
    cur = longint'($signed($urandom));
    step_max = (longint'(32'h7fff_ffff) - cur) / len;
    if ($urandom_range(0, 3) == 0 && step_max > 3) step_max = 3;
    for (int j = 0; j < len; j++) begin
      if (scrambled) begin
        vals.push_back($urandom);
      end else begin
        vals.push_back(cur[DataW-1:0]);
        cur += $urandom_range(0, 32'(step_max));
      end
    end
    for (int b = 0; b < len; b += k) begin
      stop = (b + k < len) ? b + k : len;
      for (int j = stop - 1; j > b; j--) begin
        pick = $urandom_range(b, j);
        tmp = vals[j];
        vals[j] = vals[pick];
        vals[pick] = tmp;
      end
    end
    for (int j = 0; j < len; j++) send_beat(vals[j], with_last && (j == len - 1));
  endtask

  initial begin
    int wait_cycles;
    int len;
    rst_n = 1'b0;
    cur_window = 1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset window of one: extremes and sign boundary
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sd0, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sd5, 1'b1);
    // zero window acts as one
    reconfigure(WindowAddr, 32'd0);
    send_beat(32'sd7, 1'b0);
    send_beat(-32'sd7, 1'b0);
    send_beat(32'sd7, 1'b1);
    // oversized window clamps; short sequence just flushes
    reconfigure(WindowAddr, 32'd63);
    send_beat(32'sd3, 1'b0);
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sh7fff_ffff, 1'b1);
    reconfigure(WindowAddr, 32'd4);
    reconfigure(UnusedAddr, 32'hffff_ffff);
    send_beat(32'sd42, 1'b1);
    send_beat(32'sd9, 1'b0);
    send_beat(32'sd9, 1'b0);
    send_beat(32'sd9, 1'b1);
    // shrink the window with values held
    reconfigure(WindowAddr, 32'd8);
    send_beat(32'shaaaa_aaaa, 1'b0);
    send_beat(32'sh5555_5555, 1'b0);
    send_beat(32'sh0f0f_0f0f, 1'b0);
    send_beat(32'shf0f0_f0f0, 1'b0);
    send_beat(32'sh3333_3333, 1'b0);
    send_beat(32'shcccc_cccc, 1'b0);
    reconfigure(WindowAddr, 32'd2);
    send_beat(32'sd1, 1'b0);
    send_beat(32'sd2, 1'b0);
    send_beat(32'sd3, 1'b1);

    len = items_sent + RandomItems;
    while (items_sent < len) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       reconfigure(WindowAddr, 32'd1);
          1:       reconfigure(WindowAddr, 32'd32);
          2:       reconfigure(WindowAddr, 32'd0);
          3:       reconfigure(WindowAddr, 32'd63);
          default: reconfigure(WindowAddr, $urandom_range(2, 31));
        endcase
      end
      send_run(cur_window,
               ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 40),
               $urandom_range(0, 6) == 0, $urandom_range(0, 9) != 0);
    end
    send_beat($urandom, 1'b1);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (awaited != 0 && wait_cycles < 200000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (MaxWindow + 8) @(negedge clk);
    if (awaited != 0) $error("%0d sorted beats never arrived", awaited);

    $display("sent %0d input beats over %0d register writes", items_sent, window_writes);
    $display("checked %0d sorted beats, %0d mismatches", beats_checked, fail_count);
    if (fail_count == 0 && awaited == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
